### rtl/tcw_pkg.sv
package tcw_pkg;

  // Screen geometry defaults
  localparam int DefaultCols = 80;
  localparam int DefaultRows = 25;

  // Port widths
  localparam int OpW     = 2;
  localparam int CharW   = 8;
  localparam int AttrW   = 8;
  localparam int ColInW  = 7;
  localparam int RowInW  = 5;
  localparam int IdxW    = 12;
  localparam int CfgIdxW = 1;
  localparam int CellW   = CharW + AttrW;

  // Operation codes
  localparam logic [OpW-1:0] OpPut       = 2'd0;
  localparam logic [OpW-1:0] OpBackspace = 2'd1;
  localparam logic [OpW-1:0] OpClear     = 2'd2;
  localparam logic [OpW-1:0] OpRead      = 2'd3;

  // Character codes
  localparam logic [CharW-1:0] CharBlank   = 8'h08;
  localparam logic [CharW-1:0] CharNewline = 8'h0a;
  localparam logic [CharW-1:0] CharSpace   = 8'h20;
  localparam logic [CharW-1:0] CharError   = 8'h45;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDefaultAttr = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgErrorAttr   = 1'd1;

  // Register reset values
  localparam logic [AttrW-1:0] DefaultAttrReset = 8'd15;
  localparam logic [AttrW-1:0] ErrorAttrReset   = 8'd244;

endpackage

### rtl/text_console_writer.sv
// Channel  Handshake              Payload
// in       in_valid_i/in_stall_o  op_i char_code_i attr_i use_position_i col_i row_i
// out      out_valid_o/out_stall_i next_cell_o error_o cell_char_o cell_attr_o
// cfg      cfg_valid_i/cfg_ready_o cfg_index_i cfg_data_i
//
// Put, backspace and read go through accept, execute on the cell RAM, and result.
// A put that moves the cursor past the last row adds a scroll walk that copies every
// cell one row up and zeroes the last row; clear adds a fill of the whole buffer.
// After reset a fill pass blanks the buffer; no request is accepted meanwhile,
// configuration writes are always taken.
// A stalled result is held in the output register; the next request is taken
// and holds in its result cycle until the register frees.
module text_console_writer #(
  parameter int SCREEN_COLS = tcw_pkg::DefaultCols,
  parameter int SCREEN_ROWS = tcw_pkg::DefaultRows
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tcw_pkg::OpW-1:0]      op_i,
  input  logic [tcw_pkg::CharW-1:0]    char_code_i,
  input  logic [tcw_pkg::AttrW-1:0]    attr_i,
  input  logic                         use_position_i,
  input  logic [tcw_pkg::ColInW-1:0]   col_i,
  input  logic [tcw_pkg::RowInW-1:0]   row_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tcw_pkg::IdxW-1:0]     next_cell_o,
  output logic                         error_o,
  output logic [tcw_pkg::CharW-1:0]    cell_char_o,
  output logic [tcw_pkg::AttrW-1:0]    cell_attr_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tcw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tcw_pkg::AttrW-1:0]    cfg_data_i
);

  localparam int CellCount = SCREEN_COLS * SCREEN_ROWS;
  localparam int AddrW     = $clog2(CellCount);
  localparam int CntW      = $clog2(CellCount + 1);
  localparam int ColW      = $clog2(SCREEN_COLS);
  localparam int RowW      = $clog2(SCREEN_ROWS);
  localparam int CopyLen   = CellCount - SCREEN_COLS;

  localparam logic [CntW-1:0]  CntFillLast = CntW'(CellCount - 1);
  localparam logic [CntW-1:0]  CntScrollEnd = CntW'(CellCount);
  localparam logic [CntW-1:0]  CntCopyLen  = CntW'(CopyLen);
  localparam logic [CntW-1:0]  CntColStep  = CntW'(SCREEN_COLS);
  localparam logic [AddrW-1:0] LastCell    = AddrW'(CellCount - 1);
  localparam logic [ColW:0]    ColsWide    = (ColW + 1)'(SCREEN_COLS);
  localparam logic [ColW-1:0]  ColLast     = ColW'(SCREEN_COLS - 1);
  localparam logic [RowW:0]    RowsWide    = (RowW + 1)'(SCREEN_ROWS);
  localparam logic [RowW-1:0]  RowLast     = RowW'(SCREEN_ROWS - 1);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StExec   = 6'b000010,
    StDone   = 6'b000100,
    StScroll = 6'b001000,
    StClear  = 6'b010000,
    StInit   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RowW-1:0] cur_row_q, cur_row_d;
  logic [ColW-1:0] cur_col_q, cur_col_d;
  logic [tcw_pkg::AttrW-1:0] def_attr_q, err_attr_q;

  // Latched request
  logic [tcw_pkg::OpW-1:0]    op_q;
  logic [tcw_pkg::CharW-1:0]  ch_q;
  logic [tcw_pkg::AttrW-1:0]  at_q;
  logic                       usep_q;
  logic [tcw_pkg::ColInW-1:0] col_q;
  logic [tcw_pkg::RowInW-1:0] row_q;
  logic err_q, err_d;
  logic rd_ok_q, rd_ok_d;

  logic out_valid_q;
  logic [tcw_pkg::IdxW-1:0]  out_next_q;
  logic                      out_err_q;
  logic [tcw_pkg::CharW-1:0] out_char_q;
  logic [tcw_pkg::AttrW-1:0] out_attr_q;

  logic in_accept, out_load;
  logic on_screen;
  logic [tcw_pkg::AttrW-1:0] at_eff;
  logic [RowW-1:0] t_row, bs_row;
  logic [ColW-1:0] t_col, bs_col;
  logic [ColW:0]   col_p1;
  logic [RowW:0]   row_p1, nr_wide;
  logic [ColW-1:0] nc;

  // Shared index unit: row * cols + col
  logic [tcw_pkg::RowInW-1:0] u_row;
  logic [tcw_pkg::ColInW-1:0] u_col;
  logic [tcw_pkg::IdxW-1:0]   lin;

  logic                      ram_we, ram_re;
  logic [AddrW-1:0]          ram_waddr, ram_raddr;
  logic [tcw_pkg::CellW-1:0] ram_wdata, ram_rdata;
  logic [CntW-1:0]           cnt_dec, cnt_src;

  assign in_accept   = in_valid_i && (state_q == StIdle);
  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  assign on_screen = (col_q < tcw_pkg::ColInW'(SCREEN_COLS)) &&
                     (row_q < tcw_pkg::RowInW'(SCREEN_ROWS));
  assign at_eff    = (at_q == '0) ? def_attr_q : at_q;
  assign t_row     = usep_q ? row_q[RowW-1:0] : cur_row_q;
  assign t_col     = usep_q ? col_q[ColW-1:0] : cur_col_q;
  assign col_p1    = (ColW + 1)'(t_col) + 1'b1;
  assign row_p1    = (RowW + 1)'(t_row) + 1'b1;

  // Backspace target: step back one cell, stop at cell zero
  always_comb begin
    bs_row = cur_row_q;
    bs_col = cur_col_q;
    if (cur_col_q != '0) begin
      bs_col = cur_col_q - 1'b1;
    end else if (cur_row_q != '0) begin
      bs_row = cur_row_q - 1'b1;
      bs_col = ColLast;
    end
  end

  // Cursor after a put at the target cell
  always_comb begin
    nr_wide = (RowW + 1)'(t_row);
    nc      = t_col;
    if (ch_q == tcw_pkg::CharNewline) begin
      nr_wide = row_p1;
      nc      = '0;
    end else if (ch_q != tcw_pkg::CharBlank) begin
      if (col_p1 == ColsWide) begin
        nr_wide = row_p1;
        nc      = '0;
      end else begin
        nc = col_p1[ColW-1:0];
      end
    end
  end

  always_comb begin
    if (state_q == StDone && err_q) begin
      u_row = row_q;
      u_col = col_q;
    end else if (state_q == StDone) begin
      u_row = tcw_pkg::RowInW'(cur_row_q);
      u_col = tcw_pkg::ColInW'(cur_col_q);
    end else if (op_q == tcw_pkg::OpBackspace) begin
      u_row = tcw_pkg::RowInW'(bs_row);
      u_col = tcw_pkg::ColInW'(bs_col);
    end else if (usep_q) begin
      u_row = row_q;
      u_col = col_q;
    end else begin
      u_row = tcw_pkg::RowInW'(cur_row_q);
      u_col = tcw_pkg::ColInW'(cur_col_q);
    end
  end

  assign lin = tcw_pkg::IdxW'(u_row) * tcw_pkg::IdxW'(SCREEN_COLS) + tcw_pkg::IdxW'(u_col);

  assign cnt_dec = cnt_q - 1'b1;
  assign cnt_src = cnt_q + CntColStep;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    err_d     = err_q;
    rd_ok_d   = rd_ok_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = lin[AddrW-1:0];
    ram_raddr = lin[AddrW-1:0];
    ram_wdata = {at_eff, ch_q};
    case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        err_d   = 1'b0;
        rd_ok_d = 1'b0;
        state_d = StDone;
        case (op_q)
          tcw_pkg::OpPut: begin
            if (usep_q && !on_screen) begin
              ram_we    = 1'b1;
              ram_waddr = LastCell;
              ram_wdata = {err_attr_q, tcw_pkg::CharError};
              err_d     = 1'b1;
            end else begin
              ram_we = (ch_q != tcw_pkg::CharNewline);
              if (ch_q == tcw_pkg::CharBlank) begin
                ram_wdata = {at_eff, tcw_pkg::CharSpace};
              end
              cur_col_d = nc;
              if (nr_wide == RowsWide) begin
                cur_row_d = RowLast;
                state_d   = StScroll;
              end else begin
                cur_row_d = nr_wide[RowW-1:0];
              end
            end
          end
          tcw_pkg::OpBackspace: begin
            ram_we    = 1'b1;
            ram_wdata = {def_attr_q, tcw_pkg::CharSpace};
            cur_row_d = bs_row;
            cur_col_d = bs_col;
          end
          tcw_pkg::OpClear: begin
            cur_row_d = '0;
            cur_col_d = '0;
            state_d   = StClear;
          end
          tcw_pkg::OpRead: begin
            rd_ok_d = !usep_q || on_screen;
            ram_re  = !usep_q || on_screen;
          end
          default: begin
            state_d = StDone;
          end
        endcase
      end
      StScroll: begin
        // Read the cell one row down, write the one read last cycle one row up; then zero the last row
        ram_re    = (cnt_q < CntCopyLen);
        ram_raddr = cnt_src[AddrW-1:0];
        ram_we    = (cnt_q != '0);
        ram_waddr = cnt_dec[AddrW-1:0];
        ram_wdata = (cnt_q <= CntCopyLen) ? ram_rdata : '0;
        if (cnt_q == CntScrollEnd) begin
          cnt_d   = '0;
          state_d = StDone;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StClear, StInit: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AddrW-1:0];
        ram_wdata = (state_q == StInit) ? {tcw_pkg::DefaultAttrReset, tcw_pkg::CharSpace}
                                        : {def_attr_q, tcw_pkg::CharSpace};
        if (cnt_q == CntFillLast) begin
          cnt_d   = '0;
          state_d = (state_q == StInit) ? StIdle : StDone;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  tcw_ram #(
    .Width (tcw_pkg::CellW),
    .Depth (CellCount)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StInit;
      cnt_q     <= '0;
      cur_row_q <= '0;
      cur_col_q <= '0;
      err_q     <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      err_q     <= err_d;
      rd_ok_q   <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_attr_q <= tcw_pkg::DefaultAttrReset;
      err_attr_q <= tcw_pkg::ErrorAttrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tcw_pkg::CfgDefaultAttr: def_attr_q <= cfg_data_i;
        tcw_pkg::CfgErrorAttr:   err_attr_q <= cfg_data_i;
        default: begin
          def_attr_q <= def_attr_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= op_i;
      ch_q   <= char_code_i;
      at_q   <= attr_i;
      usep_q <= use_position_i;
      col_q  <= col_i;
      row_q  <= row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_next_q <= lin;
      out_err_q  <= err_q;
      if (op_q == tcw_pkg::OpRead && rd_ok_q) begin
        out_char_q <= ram_rdata[tcw_pkg::CharW-1:0];
        out_attr_q <= ram_rdata[tcw_pkg::CellW-1:tcw_pkg::CharW];
      end else begin
        out_char_q <= '0;
        out_attr_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign next_cell_o = out_next_q;
  assign error_o     = out_err_q;
  assign cell_char_o = out_char_q;
  assign cell_attr_o = out_attr_q;

endmodule

### rtl/tcw_ram.sv
module tcw_ram #(
  parameter int Width = tcw_pkg::CellW,
  parameter int Depth = tcw_pkg::DefaultCols * tcw_pkg::DefaultRows
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
